>>> rtl/bpmc_pkg.sv
`timescale 1ns / 1ps

package bpmc_pkg;

  // Field widths of the item, the result and the registers.
  localparam int ACTION_W   = 2;
  localparam int PCT_W      = 7;
  localparam int TOTAL_W    = 20;
  localparam int SPR_W      = 11;
  localparam int TOL_W      = 8;
  localparam int STOP_W     = 8;
  localparam int SPEED_W    = 23;
  localparam int TGT_W      = 21;
  localparam int RUNSEC_W   = 8;
  localparam int REASON_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int POSITION_WIDTH_DEFAULT      = 24;
  localparam int TOLERANCE_FRAC_BITS_DEFAULT = 8;

  localparam int PCT_FULL    = 100;
  localparam int STALL_GRACE = 1;

  // The request target floor(pct * total / 100) is formed as
  // (pct * scaled) >> TGT_SHIFT with scaled = ceil(total * 2^TGT_SHIFT / 100).
  // With 2^TGT_SHIFT >= 100 * 100 the result is exact for pct up to 100.
  localparam int TGT_SHIFT    = 14;
  localparam int SCALED_W     = 28;
  localparam int TGT_WHOLE    = (2 ** TGT_SHIFT) / PCT_FULL;
  localparam int TGT_FRAC_NUM = (2 ** TGT_SHIFT) % PCT_FULL;

  // ceil(total * TGT_FRAC_NUM / 100) = floor((total * TGT_FRAC_NUM + 99) / 100),
  // the numerator stays below 2^27 and the division is a reciprocal multiply.
  localparam int FRAC_W      = 27;
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 34;
  localparam logic [RECIP_W-1:0] RECIP_PCT =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PCT_FULL) - 64'd1) / 64'(PCT_FULL));

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = '0;
  localparam logic [SPR_W-1:0]   SPR_RESET   = SPR_W'(64);
  localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(13);
  localparam logic [STOP_W-1:0]  STOP_RESET  = STOP_W'(60);
  localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(20000);

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 2'd0,
    ACT_INDEX   = 2'd1,
    ACT_REQUEST = 2'd2,
    ACT_CANCEL  = 2'd3
  } action_e;

  typedef enum logic [REASON_W-1:0] {
    RSN_NONE    = 3'd0,
    RSN_STALL   = 3'd1,
    RSN_REACHED = 3'd2,
    RSN_TIMEOUT = 3'd3,
    RSN_CANCEL  = 3'd4
  } reason_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL     = 3'd0,
    CFG_SPR       = 3'd1,
    CFG_TOLERANCE = 3'd2,
    CFG_STOP_TIME = 3'd3,
    CFG_INVERT    = 3'd4,
    CFG_MAX_SPEED = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [TOTAL_W-1:0]  total;
    logic [SCALED_W-1:0] total_scaled;
    logic [SPR_W-1:0]    steps_per_rot;
    logic [TOL_W-1:0]    tolerance;
    logic [STOP_W-1:0]   stop_time;
    logic                invert;
    logic [SPEED_W-1:0]  max_speed;
  } cfg_t;

  typedef struct packed {
    logic    accepted;
    logic    busy;
    logic    shaft_dir;
    reason_e reason;
  } status_t;

endpackage

>>> rtl/bpmc_ifs.sv
`timescale 1ns / 1ps

interface bpmc_item_if import bpmc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [PCT_W-1:0]    percentage;
  logic                second_passed;
  logic                stall_diag;

  modport source (output valid, action, percentage, second_passed, stall_diag,
                  input ready);
  modport sink (input valid, action, percentage, second_passed, stall_diag,
                output ready);
endinterface

interface bpmc_result_if import bpmc_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT
);
  logic                            valid;
  logic                            ready;
  logic                            accepted;
  logic                            busy_res;
  logic                            driver_enable;
  logic                            shaft_direction;
  logic [SPEED_W-1:0]              velocity;
  logic signed [POSITION_WIDTH-1:0] position;
  logic [REASON_W-1:0]             stop_reason;

  modport source (output valid, accepted, busy_res, driver_enable, shaft_direction,
                  velocity, position, stop_reason, input ready);
  modport sink (input valid, accepted, busy_res, driver_enable, shaft_direction,
                velocity, position, stop_reason, output ready);
endinterface

>>> rtl/bpmc_cfg.sv
`timescale 1ns / 1ps

module bpmc_cfg import bpmc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  logic [TOTAL_W-1:0]          tot_w;
  logic [FRAC_W-1:0]           frac_num;
  logic [FRAC_W+RECIP_W-1:0]   frac_prod;
  logic [TOTAL_W-1:0]          frac_ceil;
  logic [SCALED_W-1:0]         scaled;

  // Precompute the scaled travel length when it is written, so that a
  // request needs only one multiply.
  assign tot_w     = cfg_wdata_i[TOTAL_W-1:0];
  assign frac_num  = FRAC_W'(tot_w) * FRAC_W'(TGT_FRAC_NUM) + FRAC_W'(PCT_FULL - 1);
  assign frac_prod = (FRAC_W+RECIP_W)'(frac_num) * (FRAC_W+RECIP_W)'(RECIP_PCT);
  assign frac_ceil = frac_prod[RECIP_SHIFT +: TOTAL_W];
  assign scaled    = SCALED_W'(tot_w) * SCALED_W'(TGT_WHOLE) + SCALED_W'(frac_ceil);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOTAL: begin
          cfg_d.total        = tot_w;
          cfg_d.total_scaled = scaled;
        end
        CFG_SPR:       cfg_d.steps_per_rot = cfg_wdata_i[SPR_W-1:0];
        CFG_TOLERANCE: cfg_d.tolerance     = cfg_wdata_i[TOL_W-1:0];
        CFG_STOP_TIME: cfg_d.stop_time     = cfg_wdata_i[STOP_W-1:0];
        CFG_INVERT:    cfg_d.invert        = cfg_wdata_i[0];
        CFG_MAX_SPEED: cfg_d.max_speed     = cfg_wdata_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total         <= TOTAL_RESET;
      cfg_q.total_scaled  <= '0;
      cfg_q.steps_per_rot <= SPR_RESET;
      cfg_q.tolerance     <= TOL_RESET;
      cfg_q.stop_time     <= STOP_RESET;
      cfg_q.invert        <= 1'b0;
      cfg_q.max_speed     <= SPEED_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/bpmc_core.sv
`timescale 1ns / 1ps

module bpmc_core import bpmc_pkg::*; #(
  parameter int POSITION_WIDTH      = POSITION_WIDTH_DEFAULT,
  parameter int TOLERANCE_FRAC_BITS = TOLERANCE_FRAC_BITS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [ACTION_W-1:0]              action_i,
  input  logic [PCT_W-1:0]                 pct_i,
  input  logic                             second_i,
  input  logic                             stall_i,
  input  cfg_t                             cfg_i,
  output status_t                          status_o,
  output logic [SPEED_W-1:0]               velocity_o,
  output logic signed [POSITION_WIDTH-1:0] position_o
);

  localparam int PW  = POSITION_WIDTH;
  localparam int FB  = TOLERANCE_FRAC_BITS;
  localparam int PXW = ((PW > TGT_W) ? PW : TGT_W) + 1;
  localparam int TTW = TGT_W + TOL_W;
  localparam int CW  = (((TGT_W + FB) > TTW) ? (TGT_W + FB) : TTW) + 2;
  localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

  logic signed [PW-1:0]  pos_q, pos_d;
  logic [TGT_W-1:0]      tgt_q, tgt_d;
  logic                  up_q, up_d;
  logic                  trav_q, trav_d;
  logic                  run_q, run_d;
  logic                  pend_q, pend_d;
  logic [RUNSEC_W-1:0]   secs_q, secs_d;

  // Common signed views for position and target comparisons.
  logic signed [PXW-1:0] pos_x, total_x, tgt_x;
  logic signed [PW-1:0]  pos_c;

  // Arrival window, scaled by 2^TOLERANCE_FRAC_BITS.
  logic signed [CW-1:0]  pos_cx, p_s, tgt_s, tt_s, hi_s, lo_s;
  logic [TTW-1:0]        tt;
  logic                  in_window, over, reached;
  logic [RUNSEC_W-1:0]   secs_inc;
  reason_e               reason_tick;

  logic signed [PW:0]    step_x, pos_w, pos_sum;
  logic signed [PW-1:0]  pos_idx;

  logic [PCT_W-1:0]              pct_sat;
  logic [PCT_W+SCALED_W-1:0]     tgt_prod;
  logic [TGT_W-1:0]              tgt_req;
  logic signed [PXW-1:0]         tgt_req_x;

  logic    accepted;
  reason_e reason;

  assign pos_x   = PXW'(pos_q);
  assign total_x = $signed({{(PXW-TOTAL_W){1'b0}}, cfg_i.total});
  assign tgt_x   = $signed({{(PXW-TGT_W){1'b0}}, tgt_q});

  // A running motor keeps its position inside 0..total.
  always_comb begin
    if (pos_x < 0) begin
      pos_c = '0;
    end else if (pos_x > total_x) begin
      pos_c = PW'(total_x);
    end else begin
      pos_c = pos_q;
    end
  end

  assign pos_cx = CW'(pos_c);
  assign p_s    = pos_cx <<< FB;
  assign tt     = TTW'(cfg_i.tolerance) * TTW'(tgt_q);
  assign tgt_s  = $signed({{(CW-TGT_W){1'b0}}, tgt_q}) <<< FB;
  assign tt_s   = $signed({{(CW-TTW){1'b0}}, tt});
  assign hi_s   = tgt_s + tt_s;
  assign lo_s   = tgt_s - tt_s;
  assign in_window = (p_s < hi_s) && (p_s > lo_s);
  assign over   = up_q ? (p_s > hi_s) : (p_s < lo_s);
  assign reached = !trav_q && (in_window || over);

  assign secs_inc = (second_i && (secs_q != '1)) ? secs_q + RUNSEC_W'(1) : secs_q;

  always_comb begin
    if ((secs_inc > RUNSEC_W'(STALL_GRACE)) && stall_i) begin
      reason_tick = RSN_STALL;
    end else if (reached) begin
      reason_tick = RSN_REACHED;
    end else if (secs_inc > cfg_i.stop_time) begin
      reason_tick = RSN_TIMEOUT;
    end else if (pend_q) begin
      reason_tick = RSN_CANCEL;
    end else begin
      reason_tick = RSN_NONE;
    end
  end

  // Index pulse: one rotation in the travel direction, saturating.
  assign step_x  = $signed({{(PW+1-SPR_W){1'b0}}, cfg_i.steps_per_rot});
  assign pos_w   = (PW+1)'(pos_q);
  assign pos_sum = up_q ? (pos_w + step_x) : (pos_w - step_x);
  always_comb begin
    if (pos_sum[PW] != pos_sum[PW-1]) begin
      pos_idx = pos_sum[PW] ? POS_MIN : POS_MAX;
    end else begin
      pos_idx = pos_sum[PW-1:0];
    end
  end

  // Motion request target.
  assign pct_sat   = (pct_i > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct_i;
  assign tgt_prod  = (PCT_W+SCALED_W)'(pct_sat) * (PCT_W+SCALED_W)'(cfg_i.total_scaled);
  assign tgt_req   = tgt_prod[TGT_SHIFT +: TGT_W];
  assign tgt_req_x = $signed({{(PXW-TGT_W){1'b0}}, tgt_req});

  always_comb begin
    pos_d    = pos_q;
    tgt_d    = tgt_q;
    up_d     = up_q;
    trav_d   = trav_q;
    run_d    = run_q;
    pend_d   = pend_q;
    secs_d   = secs_q;
    accepted = 1'b0;
    reason   = RSN_NONE;
    case (action_e'(action_i))
      ACT_TICK: begin
        if (run_q) begin
          secs_d = secs_inc;
          pos_d  = pos_c;
          reason = reason_tick;
          if (reason_tick != RSN_NONE) begin
            run_d  = 1'b0;
            tgt_d  = pos_cx[TGT_W-1:0];
            pend_d = 1'b0;
            trav_d = 1'b0;
          end
        end else if ((tgt_x != pos_x) || trav_q) begin
          // A stop leaves target equal to position, so only a motor that
          // was already idle can start here.
          run_d  = 1'b1;
          secs_d = '0;
        end
      end
      ACT_INDEX: begin
        pos_d = pos_idx;
      end
      ACT_REQUEST: begin
        if (!run_q) begin
          tgt_d    = tgt_req;
          trav_d   = (pct_sat == PCT_W'(PCT_FULL)) || (pct_sat == '0);
          up_d     = trav_d ? (pct_sat == PCT_W'(PCT_FULL)) : (tgt_req_x > pos_x);
          accepted = 1'b1;
        end
      end
      ACT_CANCEL: begin
        pend_d = run_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      tgt_q  <= '0;
      up_q   <= 1'b0;
      trav_q <= 1'b0;
      run_q  <= 1'b0;
      pend_q <= 1'b0;
      secs_q <= '0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      tgt_q  <= tgt_d;
      up_q   <= up_d;
      trav_q <= trav_d;
      run_q  <= run_d;
      pend_q <= pend_d;
      secs_q <= secs_d;
    end
  end

  assign status_o.accepted  = accepted;
  assign status_o.busy      = run_d;
  assign status_o.shaft_dir = run_d & (up_d ^ cfg_i.invert);
  assign status_o.reason    = reason;
  assign velocity_o         = run_d ? cfg_i.max_speed : '0;
  assign position_o         = pos_d;

endmodule

>>> rtl/blind_position_motion_controller_unit.sv
`timescale 1ns / 1ps

// An accepted item waits in the input register, and its result is registered in the result
// register whenever that register is free; the result is then offered to the sink.
// Throughput: one item per cycle when the sink keeps up, set by the single controller step.
// Reset (rst_ni, asynchronous, active low) clears the controller state and both pipeline
// valid flags and loads the register defaults; there is no clearing pass.

module blind_position_motion_controller_unit import bpmc_pkg::*; #(
  parameter int POSITION_WIDTH      = POSITION_WIDTH_DEFAULT,
  parameter int TOLERANCE_FRAC_BITS = TOLERANCE_FRAC_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bpmc_item_if.sink             item_if,
  bpmc_result_if.source         result_if
);

  // Input register: holds one accepted item until the controller step runs.
  logic                in_valid_q, in_valid_d;
  logic [ACTION_W-1:0] act_q;
  logic [PCT_W-1:0]    pct_q;
  logic                sec_q;
  logic                stall_q;

  // Result register: holds one finished result until the sink takes it.
  logic                            out_valid_q, out_valid_d;
  status_t                         res_status_q, core_status;
  logic [SPEED_W-1:0]              res_speed_q, core_speed;
  logic signed [POSITION_WIDTH-1:0] res_pos_q, core_pos;

  cfg_t cfg;
  logic item_take;
  logic step;

  bpmc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The step runs whenever an item waits and the result register is empty
  // or being emptied in the same cycle. The controller state advances only
  // with the step, so items are applied strictly in order.
  assign step      = in_valid_q && (!out_valid_q || result_if.ready);
  assign item_take = item_if.valid && item_if.ready;

  // A new item may enter while the previous one steps, which gives one
  // item per cycle when the sink keeps up.
  assign item_if.ready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (item_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (result_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take) begin
      act_q   <= item_if.action;
      pct_q   <= item_if.percentage;
      sec_q   <= item_if.second_passed;
      stall_q <= item_if.stall_diag;
    end
  end

  bpmc_core #(
    .POSITION_WIDTH      (POSITION_WIDTH),
    .TOLERANCE_FRAC_BITS (TOLERANCE_FRAC_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .action_i   (act_q),
    .pct_i      (pct_q),
    .second_i   (sec_q),
    .stall_i    (stall_q),
    .cfg_i      (cfg),
    .status_o   (core_status),
    .velocity_o (core_speed),
    .position_o (core_pos)
  );

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_status_q <= core_status;
      res_speed_q  <= core_speed;
      res_pos_q    <= core_pos;
    end
  end

  assign result_if.valid           = out_valid_q;
  assign result_if.accepted        = res_status_q.accepted;
  assign result_if.busy_res        = res_status_q.busy;
  assign result_if.driver_enable   = res_status_q.busy;
  assign result_if.shaft_direction = res_status_q.shaft_dir;
  assign result_if.velocity        = res_speed_q;
  assign result_if.position        = res_pos_q;
  assign result_if.stop_reason     = res_status_q.reason;

  // A stop copies the position into the target, so the motor cannot
  // restart within the same step.
  a_stop_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && (res_status_q.reason != RSN_NONE)) |-> !res_status_q.busy)
    else $error("motor reported running on a stopping step");

  // Requests are only taken by an idle motor and never start it directly.
  a_accept_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && res_status_q.accepted) |-> !res_status_q.busy)
    else $error("accepted request shows a running motor");

  // A stopped motor drives neither speed nor direction.
  a_idle_outputs : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && !res_status_q.busy) |-> (!res_status_q.shaft_dir && (res_speed_q == '0)))
    else $error("idle motor drives speed or direction");

endmodule
